### src/isrc_pkg.sv
// Shared types, constants and the division step of the sensor result converter.
package isrc_pkg;

  localparam int FracBits = 8;    // fraction bits of both results
  localparam int DenShift = 8;    // extra scale on the normal-mode inductance divisor
  localparam int NumW     = 84;   // widest dividend, rounding half included
  localparam int DenW     = 68;   // widest divisor
  localparam int QBits    = 40;   // quotient bits, one per cell
  localparam int RpW      = 32;
  localparam int LW       = 40;
  localparam int NumCells = QBits;

  // round(9e12/(4 pi^2)), split into two 19-bit halves for the products
  localparam logic [37:0] KnConst = 38'd227972663195;
  localparam int          KnSplit = 19;
  localparam logic [18:0] KnHi    = KnConst[37:KnSplit];
  localparam logic [18:0] KnLo    = KnConst[KnSplit-1:0];
  // round(1e12*2^16/(4 pi^2))
  localparam logic [50:0] KhConst = 51'd1660046272796062;
  localparam int          KhShift = 24 + FracBits;

  localparam logic [15:0] CodeFull = 16'hFFFF;

  typedef enum logic [2:0] {
    CFG_MEASURE_MODE = 3'd0,
    CFG_HIGH_Q       = 3'd1,
    CFG_RP_LOWER     = 3'd2,
    CFG_RP_UPPER     = 3'd3,
    CFG_RESP_PERIODS = 3'd4,
    CFG_SENSOR_CAP   = 3'd5
  } isrc_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_OSC    = 2'd1,
    ST_TIMEOUT   = 2'd2,
    ST_ZERO_CODE = 2'd3
  } isrc_status_e;

  typedef struct packed {
    logic        measure_mode;
    logic        high_q_select;
    logic [16:0] rp_lower_bound_ohms;
    logic [16:0] rp_upper_bound_ohms;
    logic [12:0] response_periods;
    logic [19:0] sensor_cap_ff;
  } isrc_cfg_t;

  typedef struct packed {
    logic [15:0] rp_code;
    logic [15:0] l_code;
    logic [23:0] lhr_code;
    logic [1:0]  sensor_state;
  } isrc_req_t;

  typedef struct packed {
    logic [1:0]     result_status;
    logic           rp_valid;
    logic [RpW-1:0] rp_ohms_q8;
    logic           inductance_valid;
    logic [LW-1:0]  inductance_nh_q8;
  } isrc_res_t;

  typedef struct packed {
    isrc_status_e status;
    logic         mode;
    logic         high_q;
    logic         rp_valid;
    logic         l_valid;
  } isrc_side_t;

  typedef struct packed {
    logic [DenW-1:0]  rem;
    logic [DenW-1:0]  den;
    logic [QBits-1:0] rq;   // dividend bits still to come, quotient bits shifted in below
    logic             ovf;
  } isrc_div_t;

  typedef struct packed {
    isrc_side_t side;
    isrc_div_t  ldiv;
    isrc_div_t  rdiv;
  } isrc_cell_t;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  function automatic isrc_div_t div_step(isrc_div_t x);
    isrc_div_t     r;
    logic [DenW:0] t;
    logic          ge;
    r  = x;
    t  = {x.rem, x.rq[QBits-1]};
    ge = (t >= {1'b0, x.den});
    r.rem = ge ? DenW'(t - {1'b0, x.den}) : t[DenW-1:0];
    r.rq  = {x.rq[QBits-2:0], ge};
    return r;
  endfunction

endpackage

### src/isrc_prep.sv
// Operand preparation: products, dividends and divisors, rounding and range check.
module isrc_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  isrc_pkg::isrc_cfg_t cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  isrc_pkg::isrc_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output isrc_pkg::isrc_cell_t out_cell_o
);

  logic va_q, vb_q, vc_q, vd_q, ve_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

  isrc_pkg::isrc_side_t a_side_q, b_side_q, c_side_q, d_side_q, a_side_d;
  logic [31:0] a_lc2_q;
  logic [47:0] a_hc2_q;
  logic [25:0] a_p2_q;
  logic [32:0] a_rminrp_q, a_rmaxn_q;
  logic [33:0] a_rmm_q;
  logic [15:0] a_nrp_q, b_nrp_q;

  logic [50:0] b_knh_q, b_knl_q;
  logic [45:0] b_cp2_q;
  logic [43:0] b_chl_q, b_chh_q;
  logic [33:0] b_rden_q;
  logic [49:0] b_rmm65_q;
  logic [32:0] b_rmin65_q;

  logic [isrc_pkg::NumW-1:0] c_lnum_q, c_rnum_q, c_lnum_d, c_rnum_d;
  logic [isrc_pkg::DenW-1:0] c_lden_q, c_rden_q, c_lden_d, c_rden_d;
  logic [isrc_pkg::NumW-1:0] d_lnh_q, d_rnh_q;
  logic [isrc_pkg::DenW-1:0] d_lden_q, d_rden_q;
  isrc_pkg::isrc_cell_t e_cell_q, e_cell_d;

  assign rdy_e = !ve_q || out_ready_i;
  assign rdy_d = !vd_q || rdy_e;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign in_ready_o  = rdy_a;
  assign out_valid_o = ve_q;
  assign out_cell_o  = e_cell_q;

  // status and validity of the item
  always_comb begin
    a_side_d          = '0;
    a_side_d.status   = isrc_pkg::ST_OK;
    a_side_d.mode     = cfg_i.measure_mode;
    a_side_d.high_q   = cfg_i.high_q_select;
    if (cfg_i.measure_mode) begin
      if (in_req_i.lhr_code == '0) begin
        a_side_d.status = isrc_pkg::ST_ZERO_CODE;
      end else begin
        a_side_d.l_valid = 1'b1;
      end
    end else if (in_req_i.sensor_state != 2'd0) begin
      a_side_d.status = (in_req_i.sensor_state == 2'd1) ? isrc_pkg::ST_NO_OSC
                                                        : isrc_pkg::ST_TIMEOUT;
    end else begin
      a_side_d.rp_valid = 1'b1;
      if (in_req_i.l_code == '0) begin
        a_side_d.status = isrc_pkg::ST_ZERO_CODE;
      end else begin
        a_side_d.l_valid = 1'b1;
      end
    end
  end

  // dividends and divisors per mode
  always_comb begin
    if (b_side_q.mode) begin
      c_lnum_d = isrc_pkg::NumW'(isrc_pkg::KhConst) << isrc_pkg::KhShift;
      c_lden_d = (isrc_pkg::DenW'(b_chh_q) << 24) + isrc_pkg::DenW'(b_chl_q);
    end else begin
      c_lnum_d = (isrc_pkg::NumW'(b_knh_q) << (isrc_pkg::KnSplit + isrc_pkg::FracBits))
               + (isrc_pkg::NumW'(b_knl_q) << isrc_pkg::FracBits);
      c_lden_d = isrc_pkg::DenW'(b_cp2_q) << isrc_pkg::DenShift;
    end
    if (b_side_q.high_q) begin
      c_rnum_d = isrc_pkg::NumW'(b_rmin65_q) << isrc_pkg::FracBits;
      c_rden_d = isrc_pkg::DenW'(b_nrp_q);
    end else begin
      c_rnum_d = isrc_pkg::NumW'(b_rmm65_q) << isrc_pkg::FracBits;
      c_rden_d = isrc_pkg::DenW'(b_rden_q);
    end
  end

  // load the first cell; quotient would overflow when the top part reaches the divisor
  always_comb begin
    e_cell_d.side     = d_side_q;
    e_cell_d.ldiv.rem = isrc_pkg::DenW'(d_lnh_q[isrc_pkg::NumW-1:isrc_pkg::QBits]);
    e_cell_d.ldiv.den = d_lden_q;
    e_cell_d.ldiv.rq  = d_lnh_q[isrc_pkg::QBits-1:0];
    e_cell_d.ldiv.ovf = e_cell_d.ldiv.rem >= d_lden_q;
    e_cell_d.rdiv.rem = isrc_pkg::DenW'(d_rnh_q[isrc_pkg::NumW-1:isrc_pkg::QBits]);
    e_cell_d.rdiv.den = d_rden_q;
    e_cell_d.rdiv.rq  = d_rnh_q[isrc_pkg::QBits-1:0];
    e_cell_d.rdiv.ovf = e_cell_d.rdiv.rem >= d_rden_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
      if (rdy_e) ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      a_side_q   <= a_side_d;
      a_lc2_q    <= 32'(in_req_i.l_code) * 32'(in_req_i.l_code);
      a_hc2_q    <= 48'(in_req_i.lhr_code) * 48'(in_req_i.lhr_code);
      a_p2_q     <= 26'(cfg_i.response_periods) * 26'(cfg_i.response_periods);
      a_rminrp_q <= 33'(cfg_i.rp_lower_bound_ohms) * 33'(in_req_i.rp_code);
      a_rmaxn_q  <= 33'(cfg_i.rp_upper_bound_ohms)
                  * 33'(isrc_pkg::CodeFull - in_req_i.rp_code);
      a_rmm_q    <= 34'(cfg_i.rp_upper_bound_ohms) * 34'(cfg_i.rp_lower_bound_ohms);
      a_nrp_q    <= isrc_pkg::CodeFull - in_req_i.rp_code;
    end
    if (rdy_b) begin
      b_side_q   <= a_side_q;
      b_knh_q    <= 51'(isrc_pkg::KnHi) * 51'(a_lc2_q);
      b_knl_q    <= 51'(isrc_pkg::KnLo) * 51'(a_lc2_q);
      b_cp2_q    <= 46'(cfg_i.sensor_cap_ff) * 46'(a_p2_q);
      b_chl_q    <= 44'(cfg_i.sensor_cap_ff) * 44'(a_hc2_q[23:0]);
      b_chh_q    <= 44'(cfg_i.sensor_cap_ff) * 44'(a_hc2_q[47:24]);
      b_rden_q   <= 34'(a_rmaxn_q) + 34'(a_rminrp_q);
      b_rmm65_q  <= (50'(a_rmm_q) << 16) - 50'(a_rmm_q);
      b_rmin65_q <= (33'(cfg_i.rp_lower_bound_ohms) << 16) - 33'(cfg_i.rp_lower_bound_ohms);
      b_nrp_q    <= a_nrp_q;
    end
    if (rdy_c) begin
      c_side_q <= b_side_q;
      c_lnum_q <= c_lnum_d;
      c_lden_q <= c_lden_d;
      c_rnum_q <= c_rnum_d;
      c_rden_q <= c_rden_d;
    end
    if (rdy_d) begin
      // round to nearest: add half the divisor
      d_side_q <= c_side_q;
      d_lnh_q  <= c_lnum_q + isrc_pkg::NumW'(c_lden_q >> 1);
      d_lden_q <= c_lden_q;
      d_rnh_q  <= c_rnum_q + isrc_pkg::NumW'(c_rden_q >> 1);
      d_rden_q <= c_rden_q;
    end
    if (rdy_e) e_cell_q <= e_cell_d;
  end

endmodule

### src/isrc_div_cell.sv
// One cell of the divider chain: a quotient bit for each of the two divisions.
module isrc_div_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  isrc_pkg::isrc_cell_t in_cell_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output isrc_pkg::isrc_cell_t out_cell_o
);

  logic                 v_q;
  isrc_pkg::isrc_cell_t cell_q, cell_d;

  assign in_ready_o  = !v_q || out_ready_i;
  assign out_valid_o = v_q;
  assign out_cell_o  = cell_q;

  always_comb begin
    cell_d.side = in_cell_i.side;
    cell_d.ldiv = isrc_pkg::div_step(in_cell_i.ldiv);
    cell_d.rdiv = isrc_pkg::div_step(in_cell_i.rdiv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) cell_q <= cell_d;
  end

endmodule

### src/inductive_sensor_result_convert.sv
// Top level: converts sensor results to parallel resistance and inductance.
// The path runs through 5 preparation stages, 40 divider cells and an output register.
// Throughput: one request per cycle while the output side takes results; each
// divider cell settles one quotient bit.
// Reset: clears all stage valid bits and loads the register defaults.
module inductive_sensor_result_convert (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [19:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  isrc_pkg::isrc_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output isrc_pkg::isrc_res_t out_res_o
);

  isrc_pkg::isrc_cfg_t cfg_q;

  // chain handshake: index 0 is the preparation output, NumCells the last cell
  logic                 ch_valid [isrc_pkg::NumCells+1];
  logic                 ch_ready [isrc_pkg::NumCells+1];
  isrc_pkg::isrc_cell_t ch_cell  [isrc_pkg::NumCells+1];

  logic                 out_v_q;
  isrc_pkg::isrc_res_t  res_q, res_d;
  isrc_pkg::isrc_cell_t last;

  // configuration registers; unmapped indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.measure_mode        <= 1'b0;
      cfg_q.high_q_select       <= 1'b0;
      cfg_q.rp_lower_bound_ohms <= 17'd750;
      cfg_q.rp_upper_bound_ohms <= 17'd96000;
      cfg_q.response_periods    <= 13'd128;
      cfg_q.sensor_cap_ff       <= 20'd100000;
    end else if (cfg_we_i) begin
      case (isrc_pkg::isrc_cfg_idx_e'(cfg_idx_i))
        isrc_pkg::CFG_MEASURE_MODE: cfg_q.measure_mode        <= cfg_data_i[0];
        isrc_pkg::CFG_HIGH_Q:       cfg_q.high_q_select       <= cfg_data_i[0];
        isrc_pkg::CFG_RP_LOWER:     cfg_q.rp_lower_bound_ohms <= cfg_data_i[16:0];
        isrc_pkg::CFG_RP_UPPER:     cfg_q.rp_upper_bound_ohms <= cfg_data_i[16:0];
        isrc_pkg::CFG_RESP_PERIODS: cfg_q.response_periods    <= cfg_data_i[12:0];
        isrc_pkg::CFG_SENSOR_CAP:   cfg_q.sensor_cap_ff       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // multiplier pipeline building dividends and divisors
  isrc_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(ch_valid[0]),
    .out_ready_i(ch_ready[0]),
    .out_cell_o (ch_cell[0])
  );

  // restoring divider, one cell per quotient bit, both divisions side by side
  for (genvar k = 0; k < isrc_pkg::NumCells; k++) begin : g_cell
    isrc_div_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (ch_valid[k]),
      .in_ready_o (ch_ready[k]),
      .in_cell_i  (ch_cell[k]),
      .out_valid_o(ch_valid[k+1]),
      .out_ready_i(ch_ready[k+1]),
      .out_cell_o (ch_cell[k+1])
    );
  end

  assign ch_ready[isrc_pkg::NumCells] = !out_v_q || out_ready_i;
  assign last = ch_cell[isrc_pkg::NumCells];

  // saturate on quotient overflow (a zero divisor lands here too), zero unused fields
  always_comb begin
    res_d                  = '0;
    res_d.result_status    = last.side.status;
    res_d.rp_valid         = last.side.rp_valid;
    res_d.inductance_valid = last.side.l_valid;
    if (last.side.rp_valid) begin
      if (last.rdiv.ovf || (last.rdiv.rq[isrc_pkg::QBits-1:isrc_pkg::RpW] != '0)) begin
        res_d.rp_ohms_q8 = '1;
      end else begin
        res_d.rp_ohms_q8 = last.rdiv.rq[isrc_pkg::RpW-1:0];
      end
    end
    if (last.side.l_valid) begin
      res_d.inductance_nh_q8 = last.ldiv.ovf ? '1 : last.ldiv.rq[isrc_pkg::LW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ch_ready[isrc_pkg::NumCells]) begin
      out_v_q <= ch_valid[isrc_pkg::NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ch_ready[isrc_pkg::NumCells]) res_q <= res_d;
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = res_q;

  // an empty output register leaves the whole chain free to take a request
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> in_ready_o) else $error("input stalled with empty output");

  a_l_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && res_q.inductance_valid |-> res_q.result_status == isrc_pkg::ST_OK)
    else $error("valid inductance with error status");

  a_rp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !res_q.rp_valid |-> res_q.rp_ohms_q8 == '0)
    else $error("invalid resistance not zero");

  a_l_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !res_q.inductance_valid |-> res_q.inductance_nh_q8 == '0)
    else $error("invalid inductance not zero");

endmodule
